FILE: rtl/p2ae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2ae_pkg
// Shared widths, types and constants of the azimuth/elevation datapath.
// ----------------------------------------------------------------------------
package p2ae_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int N_ROT = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    localparam int SCALE_SHIFT = 55 - COORD_WIDTH;
    localparam int CW          = COORD_WIDTH + SCALE_SHIFT + 4;
    localparam int ACC_W       = 34;
    localparam int ROUND_SHIFT = 32 - ANGLE_WIDTH;
    localparam int EL_W        = ACC_W - ROUND_SHIFT;

    localparam int KINV_SHIFT = 30;
    localparam int HI_W       = CW - 1 - KINV_SHIFT;
    localparam logic [KINV_SHIFT-1:0] KINV_Q30 = KINV_SHIFT'(652032874);

    typedef logic signed [CW-1:0]          t_cw;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [ANGLE_WIDTH-1:0] t_ang;
    typedef logic signed [EL_W-1:0]        t_el;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    localparam t_acc ACC_PI    = t_acc'(64'd1 << 31);
    localparam t_acc ACC_HALF  = t_acc'(64'd1 << (31 - ANGLE_WIDTH));
    localparam t_ang ANG_QUARTER = t_ang'(32'd1 << (ANGLE_WIDTH - 2));
    localparam t_el  EL_QUARTER  = t_el'(32'd1 << (ANGLE_WIDTH - 2));

    localparam t_acc ATAN_TAB [ATAN_ENTRIES] = '{
        t_acc'(536870912), t_acc'(316933406), t_acc'(167458907), t_acc'(85004756),
        t_acc'(42667331),  t_acc'(21354465),  t_acc'(10679838),  t_acc'(5340245),
        t_acc'(2670163),   t_acc'(1335087),   t_acc'(667544),    t_acc'(333772),
        t_acc'(166886),    t_acc'(83443),     t_acc'(41722),     t_acc'(20861),
        t_acc'(10430),     t_acc'(5215),      t_acc'(2608),      t_acc'(1304),
        t_acc'(652),       t_acc'(326),       t_acc'(163),       t_acc'(81)
    };

    typedef struct packed {
        logic       zero;
        t_coord     py;
        t_ang       az;
    } t_side;

endpackage

FILE: rtl/p2ae_vector_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2ae_vector_pass
// Pipelined CORDIC vectoring pass, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module p2ae_vector_pass
    import p2ae_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cw   i_x,
    input  t_cw   i_y,
    input  t_acc  i_acc,
    input  t_side i_side,
    output logic  o_valid,
    input  logic  i_ready,
    output t_cw   o_x,
    output t_acc  o_acc,
    output t_side o_side
);

    logic  w_v    [0:N_ROT];
    logic  w_en   [0:N_ROT];
    t_cw   w_x    [0:N_ROT];
    t_cw   w_y    [0:N_ROT-1];
    t_acc  w_acc  [0:N_ROT];
    t_side w_side [0:N_ROT];

    logic  r_v    [N_ROT];
    t_cw   r_x    [N_ROT];
    t_acc  r_acc  [N_ROT];
    t_side r_side [N_ROT];

    assign w_v[0]    = i_valid;
    assign w_x[0]    = i_x;
    assign w_y[0]    = i_y;
    assign w_acc[0]  = i_acc;
    assign w_side[0] = i_side;
    assign w_en[N_ROT] = i_ready;

    for (genvar k = 0; k < N_ROT; k++) begin : g_stage
        t_cw  w_xs;
        t_cw  w_ys;
        t_cw  n_x;
        t_acc n_acc;

        assign w_xs = w_x[k] >>> k;
        assign w_ys = w_y[k] >>> k;
        assign n_x   = w_y[k][CW-1] ? (w_x[k] - w_ys) : (w_x[k] + w_ys);
        assign n_acc = w_y[k][CW-1] ? (w_acc[k] - ATAN_TAB[k]) : (w_acc[k] + ATAN_TAB[k]);
        assign w_en[k] = !r_v[k] || w_en[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_x[k]    <= n_x;
                r_acc[k]  <= n_acc;
                r_side[k] <= w_side[k];
            end
        end

        if (k < N_ROT - 1) begin : g_y
            t_cw n_y;
            t_cw r_y;

            assign n_y = w_y[k][CW-1] ? (w_y[k] + w_xs) : (w_y[k] - w_xs);

            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_y <= n_y;
                end
            end

            assign w_y[k+1] = r_y;
        end

        assign w_v[k+1]    = r_v[k];
        assign w_x[k+1]    = r_x[k];
        assign w_acc[k+1]  = r_acc[k];
        assign w_side[k+1] = r_side[k];
    end

    assign o_ready = w_en[0];
    assign o_valid = w_v[N_ROT];
    assign o_x     = w_x[N_ROT];
    assign o_acc   = w_acc[N_ROT];
    assign o_side  = w_side[N_ROT];

endmodule

FILE: rtl/p2ae_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2ae_gain
// Two-stage CORDIC gain correction: split product, then rounded recombine.
// ----------------------------------------------------------------------------
module p2ae_gain
    import p2ae_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_cw   i_x,
    input  t_side i_side,
    output logic  o_valid,
    input  logic  i_ready,
    output t_cw   o_h,
    output t_side o_side
);

    localparam int PHI_W = HI_W + KINV_SHIFT;
    localparam int PLO_W = 2 * KINV_SHIFT;

    logic                    r_v1;
    logic [PHI_W-1:0]        r_phi;
    logic [PLO_W-1:0]        r_plo;
    t_side                   r_side1;
    logic                    r_v2;
    t_cw                     r_h;
    t_side                   r_side2;

    logic                    w_en1;
    logic                    w_en2;
    logic [HI_W-1:0]         w_hi;
    logic [KINV_SHIFT-1:0]   w_lo;
    logic [PLO_W:0]          w_lo_sum;
    t_cw                     n_h;

    assign w_hi = i_x[CW-2:KINV_SHIFT];
    assign w_lo = i_x[KINV_SHIFT-1:0];

    assign w_lo_sum = {1'b0, r_plo} + (PLO_W+1)'(64'd1 << (KINV_SHIFT - 1));
    assign n_h = t_cw'({1'b0, r_phi}) + t_cw'({1'b0, w_lo_sum[PLO_W:KINV_SHIFT]});

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_phi   <= PHI_W'(w_hi) * PHI_W'(KINV_Q30);
            r_plo   <= PLO_W'(w_lo) * PLO_W'(KINV_Q30);
            r_side1 <= i_side;
        end
        if (w_en2) begin
            r_h     <= n_h;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_h     = r_h;
    assign o_side  = r_side2;

endmodule

FILE: rtl/point_to_azimuth_elevation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_azimuth_elevation
// Equirectangular angles of a 3D point by two pipelined CORDIC passes.
// Register stages: input stage, 16 azimuth rotations, 2 gain stages,
// 16 elevation rotations, output stage. Throughput: one item per cycle
// while i_ready is high, set by one micro-rotation per stage in each pass.
// Reset clears the valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module point_to_azimuth_elevation
    import p2ae_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_coord i_point_x,
    input  t_coord i_point_y,
    input  t_coord i_point_z,
    output logic   o_valid,
    input  logic   i_ready,
    output t_ang   o_azimuth,
    output t_ang   o_elevation
);

    // input stage
    logic  r_in_v;
    t_cw   r_in_x;
    t_cw   r_in_y;
    t_acc  r_in_acc;
    t_side r_in_side;
    logic  w_in_en;
    t_cw   w_sx;
    t_cw   w_sz;
    t_acc  n_in_acc;
    t_side n_in_side;

    // pass 1 / gain / pass 2
    logic  w_p1_ready;
    logic  w_p1_v;
    t_cw   w_p1_x;
    t_acc  w_p1_acc;
    t_side w_p1_side;
    t_side w_g_in_side;
    t_acc  w_az_sum;
    logic  w_g_ready;
    logic  w_g_v;
    t_cw   w_g_h;
    t_side w_g_side;
    logic  w_p2_ready;
    logic  w_p2_v;
    t_acc  w_p2_acc;
    t_side w_p2_side;

    // output stage
    logic  r_out_v;
    t_ang  r_az;
    t_ang  r_el;
    logic  w_out_en;
    t_acc  w_el_sum;
    t_el   w_el_full;
    t_el   w_el_clamp;
    t_ang  n_el;

    assign w_sx = t_cw'(i_point_x) <<< SCALE_SHIFT;
    assign w_sz = t_cw'(i_point_z) <<< SCALE_SHIFT;

    always_comb begin
        n_in_side.zero = (i_point_x == '0) && (i_point_z == '0);
        n_in_side.py   = i_point_y;
        n_in_side.az   = '0;
        n_in_acc       = '0;
        if (i_point_z[COORD_WIDTH-1]) begin
            n_in_acc = i_point_x[COORD_WIDTH-1] ? -ACC_PI : ACC_PI;
        end
    end

    assign w_in_en = !r_in_v || w_p1_ready;
    assign o_ready = w_in_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_en) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_en) begin
            r_in_x    <= i_point_z[COORD_WIDTH-1] ? -w_sz : w_sz;
            r_in_y    <= i_point_z[COORD_WIDTH-1] ? -w_sx : w_sx;
            r_in_acc  <= n_in_acc;
            r_in_side <= n_in_side;
        end
    end

    p2ae_vector_pass u_pass_az (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .o_ready (w_p1_ready),
        .i_x     (r_in_x),
        .i_y     (r_in_y),
        .i_acc   (r_in_acc),
        .i_side  (r_in_side),
        .o_valid (w_p1_v),
        .i_ready (w_g_ready),
        .o_x     (w_p1_x),
        .o_acc   (w_p1_acc),
        .o_side  (w_p1_side)
    );

    assign w_az_sum = w_p1_acc + ACC_HALF;

    always_comb begin
        w_g_in_side = w_p1_side;
        w_g_in_side.az = w_p1_side.zero ? '0
                       : w_az_sum[ROUND_SHIFT+ANGLE_WIDTH-1:ROUND_SHIFT];
    end

    p2ae_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_p1_v),
        .o_ready (w_g_ready),
        .i_x     (w_p1_x),
        .i_side  (w_g_in_side),
        .o_valid (w_g_v),
        .i_ready (w_p2_ready),
        .o_h     (w_g_h),
        .o_side  (w_g_side)
    );

    p2ae_vector_pass u_pass_el (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_g_v),
        .o_ready (w_p2_ready),
        .i_x     (w_g_h),
        .i_y     (t_cw'(w_g_side.py) <<< SCALE_SHIFT),
        .i_acc   (t_acc'(0)),
        .i_side  (w_g_side),
        .o_valid (w_p2_v),
        .i_ready (w_out_en),
        .o_x     (),
        .o_acc   (w_p2_acc),
        .o_side  (w_p2_side)
    );

    assign w_el_sum  = w_p2_acc + ACC_HALF;
    assign w_el_full = w_el_sum[ACC_W-1:ROUND_SHIFT];

    always_comb begin
        w_el_clamp = w_el_full;
        if (w_el_full > EL_QUARTER) begin
            w_el_clamp = EL_QUARTER;
        end
        if (w_el_full < -EL_QUARTER) begin
            w_el_clamp = -EL_QUARTER;
        end
        n_el = w_el_clamp[ANGLE_WIDTH-1:0];
        if (w_p2_side.zero) begin
            if (w_p2_side.py[COORD_WIDTH-1]) begin
                n_el = -ANG_QUARTER;
            end else if (w_p2_side.py != '0) begin
                n_el = ANG_QUARTER;
            end else begin
                n_el = '0;
            end
        end
    end

    assign w_out_en = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_en) begin
            r_out_v <= w_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_az <= w_p2_side.az;
            r_el <= n_el;
        end
    end

    assign o_valid     = r_out_v;
    assign o_azimuth   = r_az;
    assign o_elevation = r_el;

    a_el_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elevation <= ANG_QUARTER && o_elevation >= -ANG_QUARTER))
        else $error("elevation outside quarter turn");

    a_gain_input_nonneg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p1_v |-> !w_p1_x[CW-1])
        else $error("negative magnitude into gain correction");

    a_zero_azimuth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_p2_v && w_p2_side.zero) |-> (w_p2_side.az == '0))
        else $error("azimuth of on-axis item not zero");

endmodule
